@@ design/pwfp_pkg.sv @@
// Shared types and constants for the protobuf wire field parser.
`default_nettype none
package pwfp_pkg;

  localparam int MAX_VARINT_BYTES_DEF = 10;
  localparam int LENGTH_BITS_DEF      = 32;

  localparam int VALUE_W     = 64;
  localparam int FIELD_NUM_W = 29;
  localparam int WIRE_TYPE_W = 3;
  localparam int BYTE_W      = 8;
  localparam int KIND_W      = 3;
  localparam int OUT_DATA_W  = 112;
  localparam int VARINT_DATA_BITS = 7;
  localparam int SHIFT_W     = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_VARINT    = 3'd0,
    KIND_LENGTH    = 3'd1,
    KIND_PAYLOAD   = 3'd2,
    KIND_SKIPPED   = 3'd3,
    KIND_UNKNOWN   = 3'd4,
    KIND_TRUNCATED = 3'd5
  } kind_t;

  typedef enum logic [WIRE_TYPE_W-1:0] {
    WT_VARINT  = 3'd0,
    WT_FIXED64 = 3'd1,
    WT_LENGTH  = 3'd2,
    WT_FIXED32 = 3'd5
  } wire_code_t;

  localparam int FIXED64_BYTES = 8;
  localparam int FIXED32_BYTES = 4;

  typedef struct packed {
    kind_t                    kind;
    logic [FIELD_NUM_W-1:0]   field_number;
    logic [WIRE_TYPE_W-1:0]   wire_type;
    logic [VALUE_W-1:0]       value;
    logic [BYTE_W-1:0]        payload_byte;
    logic                     payload_last;
    logic                     message_end;
  } result_t;

endpackage
`default_nettype wire

@@ design/pwfp_parse.sv @@
// Parse state and per-byte decode logic: one byte in, at most one result out.
`default_nettype none
module pwfp_parse #(
  parameter int MAX_VARINT_BYTES = pwfp_pkg::MAX_VARINT_BYTES_DEF,
  parameter int LENGTH_BITS      = pwfp_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          advance,
  input  wire logic [pwfp_pkg::BYTE_W-1:0]   in_byte,
  input  wire logic                          in_last,
  output logic                               res_valid,
  output pwfp_pkg::result_t                  res
);
  import pwfp_pkg::*;

  localparam int CNT_W = $clog2(MAX_VARINT_BYTES + 1);

  typedef enum logic [2:0] {
    PH_TAG     = 3'd0,
    PH_VALUE   = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_SKIP    = 3'd4
  } phase_t;

  phase_t                  phase, phase_next;
  logic [VALUE_W-1:0]      accumulator, accumulator_next;
  logic [CNT_W-1:0]        varint_byte_count, varint_byte_count_next;
  logic [FIELD_NUM_W-1:0]  held_field_number, held_field_number_next;
  logic [WIRE_TYPE_W-1:0]  held_wire_type, held_wire_type_next;
  logic [LENGTH_BITS-1:0]  bytes_remaining, bytes_remaining_next;

  always_comb begin
    logic [LENGTH_BITS-1:0] rem_dec;
    logic [CNT_W-1:0]       cnt_eff;
    logic [SHIFT_W-1:0]     shamt;
    logic [VALUE_W-1:0]     acc_new;
    logic [LENGTH_BITS-1:0] len_sat;
    logic                   done;

    phase_next             = phase;
    accumulator_next       = accumulator;
    varint_byte_count_next = varint_byte_count;
    held_field_number_next = held_field_number;
    held_wire_type_next    = held_wire_type;
    bytes_remaining_next   = bytes_remaining;
    res_valid              = 1'b0;
    res                    = '0;
    res.message_end        = in_last;
    res.field_number       = held_field_number;
    res.wire_type          = held_wire_type;

    // An empty counter behaves as if one byte were left.
    rem_dec = (bytes_remaining == '0) ? '0 : bytes_remaining - LENGTH_BITS'(1);
    cnt_eff = (varint_byte_count >= CNT_W'(MAX_VARINT_BYTES)) ?
              CNT_W'(MAX_VARINT_BYTES - 1) : varint_byte_count;
    shamt   = SHIFT_W'(cnt_eff) * SHIFT_W'(VARINT_DATA_BITS);
    acc_new = accumulator | ({{(VALUE_W-VARINT_DATA_BITS){1'b0}},
                              in_byte[VARINT_DATA_BITS-1:0]} << shamt);
    done    = !in_byte[BYTE_W-1] ||
              ((cnt_eff + CNT_W'(1)) >= CNT_W'(MAX_VARINT_BYTES));
    len_sat = (|acc_new[VALUE_W-1:LENGTH_BITS]) ? '1 : acc_new[LENGTH_BITS-1:0];

    case (phase)
      PH_PAYLOAD, PH_SKIP: begin
        bytes_remaining_next = rem_dec;
        if (phase == PH_PAYLOAD) begin
          res_valid        = 1'b1;
          res.kind         = KIND_PAYLOAD;
          res.payload_byte = in_byte;
          res.payload_last = (rem_dec == '0);
        end else if (rem_dec == '0) begin
          res_valid = 1'b1;
          res.kind  = KIND_SKIPPED;
        end
        if (rem_dec == '0) phase_next = PH_TAG;
      end
      default: begin
        if (phase != PH_VALUE && phase != PH_LENGTH) phase_next = PH_TAG;
        accumulator_next       = acc_new;
        varint_byte_count_next = cnt_eff + CNT_W'(1);
        if (done) begin
          accumulator_next       = '0;
          varint_byte_count_next = '0;
          if (phase == PH_VALUE) begin
            res_valid  = 1'b1;
            res.kind   = KIND_VARINT;
            res.value  = acc_new;
            phase_next = PH_TAG;
          end else if (phase == PH_LENGTH) begin
            res_valid  = 1'b1;
            res.kind   = KIND_LENGTH;
            res.value  = acc_new;
            if (acc_new == '0) begin
              phase_next = PH_TAG;
            end else begin
              bytes_remaining_next = len_sat;
              phase_next           = PH_PAYLOAD;
            end
          end else begin
            held_field_number_next = acc_new[FIELD_NUM_W+WIRE_TYPE_W-1:WIRE_TYPE_W];
            held_wire_type_next    = acc_new[WIRE_TYPE_W-1:0];
            res.field_number       = acc_new[FIELD_NUM_W+WIRE_TYPE_W-1:WIRE_TYPE_W];
            res.wire_type          = acc_new[WIRE_TYPE_W-1:0];
            case (acc_new[WIRE_TYPE_W-1:0])
              WT_VARINT: phase_next = PH_VALUE;
              WT_LENGTH: phase_next = PH_LENGTH;
              WT_FIXED64: begin
                bytes_remaining_next = LENGTH_BITS'(FIXED64_BYTES);
                phase_next           = PH_SKIP;
              end
              WT_FIXED32: begin
                bytes_remaining_next = LENGTH_BITS'(FIXED32_BYTES);
                phase_next           = PH_SKIP;
              end
              default: begin
                res_valid = 1'b1;
                res.kind  = KIND_UNKNOWN;
              end
            endcase
          end
        end
      end
    endcase

    // The final byte closes the message: an open field turns into a truncation.
    if (in_last) begin
      if (phase_next != PH_TAG || varint_byte_count_next != '0) begin
        res_valid        = 1'b1;
        res              = '0;
        res.kind         = KIND_TRUNCATED;
        res.message_end  = 1'b1;
        if (phase_next != PH_TAG) begin
          res.field_number = held_field_number_next;
          res.wire_type    = held_wire_type_next;
        end
      end
      phase_next             = PH_TAG;
      accumulator_next       = '0;
      varint_byte_count_next = '0;
      held_field_number_next = '0;
      held_wire_type_next    = '0;
      bytes_remaining_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_TAG;
      accumulator       <= '0;
      varint_byte_count <= '0;
      held_field_number <= '0;
      held_wire_type    <= '0;
      bytes_remaining   <= '0;
    end else if (advance) begin
      phase             <= phase_next;
      accumulator       <= accumulator_next;
      varint_byte_count <= varint_byte_count_next;
      held_field_number <= held_field_number_next;
      held_wire_type    <= held_wire_type_next;
      bytes_remaining   <= bytes_remaining_next;
    end
  end

endmodule
`default_nettype wire

@@ design/protobuf_wire_field_parser.sv @@
// Top level of the protobuf wire field parser: input register, decoder, result register.
//
//   Channel  Direction  Payload
//   s_axis   in         tdata: in_byte; tlast: end_of_message
//   m_axis   out        tdata: field_number, wire_type, value, payload_byte,
//                       payload_last; tuser: kind; tlast: message_end
//
// A new byte is taken every cycle when the output flows.
// A result is offered from the result register once its byte has passed the input register and decoder.
// Bytes that produce no result only update the parse state.
// While a result waits on m_axis, one more byte may sit in the input register.
// Synchronous reset returns the parser to the tag phase and drops both registers.
`default_nettype none
module protobuf_wire_field_parser #(
  parameter int MAX_VARINT_BYTES = pwfp_pkg::MAX_VARINT_BYTES_DEF,
  parameter int LENGTH_BITS      = pwfp_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [7:0]                        s_axis_tdata,  // [7:0] in_byte
  input  wire logic                              s_axis_tlast,  // end_of_message
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [28:0] field_number, [31:29] wire_type, [95:32] value,
  // [103:96] payload_byte, [104] payload_last, [111:105] zero
  output logic [pwfp_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  output logic [pwfp_pkg::KIND_W-1:0]            m_axis_tuser,  // [2:0] kind
  output logic                                   m_axis_tlast   // message_end
);
  import pwfp_pkg::*;

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;
  logic              advance;
  logic              res_valid;
  result_t           res;
  logic              out_valid;
  result_t           out_res;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  pwfp_parse #(
    .MAX_VARINT_BYTES (MAX_VARINT_BYTES),
    .LENGTH_BITS      (LENGTH_BITS)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.kind;
  assign m_axis_tlast  = out_res.message_end;
  assign m_axis_tdata  = {7'b0, out_res.payload_last, out_res.payload_byte,
                          out_res.value, out_res.wire_type, out_res.field_number};

endmodule
`default_nettype wire

@@ design/pwfp_checker.sv @@
// Port-level checks for the protobuf wire field parser, bound to the top level.
`default_nettype none
module pwfp_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [pwfp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input wire logic [pwfp_pkg::KIND_W-1:0]       m_axis_tuser,
  input wire logic                              m_axis_tlast
);
  import pwfp_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_last_only_payload: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[104] |-> m_axis_tuser == KIND_PAYLOAD)
    else $error("payload_last set on a non-payload item");

  a_trunc_ends: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_TRUNCATED |->
      m_axis_tlast && m_axis_tdata[95:32] == '0)
    else $error("truncated item without message end or with a value");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != KIND_VARINT && m_axis_tuser != KIND_LENGTH
      |-> m_axis_tdata[95:32] == '0)
    else $error("value set on an item that carries none");

endmodule

bind protobuf_wire_field_parser pwfp_checker u_pwfp_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
